/* rtl/gcfc_pkg.sv */
`default_nettype none

package gcfc_pkg;

  localparam int COORD_W = 25;
  localparam int CODE_W = 57;

  // Packed digit span of one lane (millions digit can reach 16).
  localparam int PART_W = 53;

  // Digits below millions, one divide-by-ten stage each.
  localparam int DIV_STAGES = 6;
  localparam int DIGIT_W = 4;
  localparam int MILL_W = 5;

  // floor(v / 10) == (v * RECIP) >> SHIFT, exact for v < 2**26
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 25'd26843546;
  localparam int DIV10_SHIFT = 28;
  localparam int PROD_W = COORD_W + RECIP_W;
  localparam int QUO_W = PROD_W - DIV10_SHIFT;

  // sign split + divide stages + sign apply + merge add
  localparam int LATENCY = DIV_STAGES + 3;

  typedef struct packed {
    logic nz;
    logic neg;
  } sign_t;

endpackage

`default_nettype wire

/* rtl/gcfc_lane.sv */
`default_nettype none

module gcfc_lane
  import gcfc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [COORD_W-1:0] coord,
  output logic             [CODE_W-1:0]  part
);

  logic  [COORD_W-1:0]            quo  [0:DIV_STAGES];
  logic  [DIGIT_W*DIV_STAGES-1:0] digs [0:DIV_STAGES];
  sign_t                          sgn  [0:DIV_STAGES];

  // sign split; magnitude of the most negative code still fits unsigned
  always_ff @(posedge clk) begin
    sgn[0].nz  <= |coord;
    sgn[0].neg <= coord[COORD_W-1];
    quo[0]     <= coord[COORD_W-1] ? (~coord + 1'b1) : coord;
    digs[0]    <= '0;
  end

  // each stage peels off the lowest decimal digit, ones first
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [PROD_W-1:0]  prod;
    logic [QUO_W-1:0]   q;
    logic [COORD_W-1:0] q_ext;
    logic [COORD_W-1:0] rem;

    always_comb begin
      prod  = PROD_W'(quo[k-1]) * PROD_W'(DIV10_RECIP);
      q     = prod[PROD_W-1:DIV10_SHIFT];
      q_ext = COORD_W'(q);
      rem   = quo[k-1] - ((q_ext << 3) + (q_ext << 1));
    end

    always_ff @(posedge clk) begin
      quo[k]  <= q_ext;
      digs[k] <= {rem[DIGIT_W-1:0], digs[k-1][DIGIT_W*DIV_STAGES-1:DIGIT_W]};
      sgn[k]  <= sgn[k-1];
    end
  end

  // even-nibble interleave: 10**j digit at nibble 2j, millions at nibble 12
  logic [PART_W-1:0] inter;
  logic [CODE_W-1:0] inter_ext;

  always_comb begin
    inter = '0;
    inter[PART_W-1 -: MILL_W] = quo[DIV_STAGES][MILL_W-1:0];
    for (int j = 0; j < DIV_STAGES; j++) begin
      inter[2*DIGIT_W*j +: DIGIT_W] = digs[DIV_STAGES][DIGIT_W*j +: DIGIT_W];
    end
    inter_ext = CODE_W'(inter);
  end

  always_ff @(posedge clk) begin
    if (!sgn[DIV_STAGES].nz) begin
      part <= '0;
    end else if (sgn[DIV_STAGES].neg) begin
      part <= ~inter_ext + 1'b1;
    end else begin
      part <= inter_ext;
    end
  end

endmodule

`default_nettype wire

/* rtl/grid_code_from_coordinates_core.sv */
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// Latency is set by the six divide-by-ten stages in each coordinate lane,
// plus sign split, sign apply and the final merge adder.
// Reset (synchronous, active high) clears the valid pipeline only; results
// are strobed for one cycle, since the receiver cannot stall.
`default_nettype none

module grid_code_from_coordinates_core
  import gcfc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] x_coord,
  input  wire logic signed [COORD_W-1:0] y_coord,
  output logic                           done,
  output logic signed      [CODE_W-1:0]  grid_code
);

  logic [CODE_W-1:0]  x_part;
  logic [CODE_W-1:0]  y_part;
  logic [LATENCY-1:0] vld;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  gcfc_lane u_lane_x (
    .clk   (clk),
    .coord (x_coord),
    .part  (x_part)
  );

  gcfc_lane u_lane_y (
    .clk   (clk),
    .coord (y_coord),
    .part  (y_part)
  );

  // x digits sit one nibble above y; shifting after negation is still exact mod 2**57
  always_ff @(posedge clk) begin
    grid_code <= signed'({x_part[CODE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + y_part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  assign done = vld[LATENCY-1];

`ifndef SYNTHESIS
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, LATENCY))
    else $error("done without a matching start transfer");

  a_zero_in_zero_out: assert property (@(posedge clk) disable iff (rst)
    (accept && x_coord == '0 && y_coord == '0) |-> ##LATENCY (grid_code == '0))
    else $error("zero coordinates gave a nonzero code");

  a_pos_y_nonneg: assert property (@(posedge clk) disable iff (rst)
    (accept && x_coord == '0 && !y_coord[COORD_W-1]) |-> ##LATENCY
      (!grid_code[CODE_W-1] && done))
    else $error("nonnegative northing alone gave a negative code");
`endif

endmodule

`default_nettype wire
